// ===== hw/rtl/mgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgs_pkg
// Shared constants and helper functions for the maze generator and solver.
// ----------------------------------------------------------------------------
package mgs_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 32;

  localparam logic [2:0] PH_GEN     = 3'd0;
  localparam logic [2:0] PH_SEEDED  = 3'd1;
  localparam logic [2:0] PH_SOLVING = 3'd2;
  localparam logic [2:0] PH_SOLVED  = 3'd3;
  localparam logic [2:0] PH_STUCK   = 3'd4;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ADV  = 2'd1;
  localparam logic [1:0] ACT_BACK = 2'd2;
  localparam logic [1:0] ACT_GOAL = 2'd3;

  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_START_COL = 2'd2;
  localparam logic [1:0] REG_START_ROW = 2'd3;

  localparam logic [4:0] VISITED_FLAG = 5'h10;

  localparam logic [6:0] RST_WIDTH  = 7'd40;
  localparam logic [5:0] RST_HEIGHT = 6'd25;

  // wall bit of a direction and of its opposite side
  function automatic logic [3:0] open_bit(input logic [1:0] d);
    return 4'b0001 << d;
  endfunction

  function automatic logic [3:0] back_bit(input logic [1:0] d);
    return 4'b0001 << (d + 2'd2);
  endfunction

  // word mod 3 by summing base-4 digits (4 is 1 mod 3)
  function automatic logic [1:0] mod3(input logic [15:0] w);
    logic [4:0] s;
    logic [2:0] t;
    s = 5'(w[1:0]) + 5'(w[3:2]) + 5'(w[5:4]) + 5'(w[7:6]) +
        5'(w[9:8]) + 5'(w[11:10]) + 5'(w[13:12]) + 5'(w[15:14]);
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) t = t - 3'd6;
    else if (t >= 3'd3) t = t - 3'd3;
    return t[1:0];
  endfunction

  // word mod n for n in 1..4
  function automatic logic [1:0] pick_mod(input logic [15:0] w, input logic [2:0] n);
    logic [1:0] r;
    case (n)
      3'd2:    r = {1'b0, w[0]};
      3'd3:    r = mod3(w);
      3'd4:    r = w[1:0];
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/maze_generate_and_solve_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_generate_and_solve_top
// One maze step per item: backtracking generator, then depth-first solver.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (random_word) carries one tick; out channel returns one result
//   item per tick. cfg channel writes registers 0..3 and restarts the run.
//   Each item walks a small sequencer: stack top read, four neighbour reads
//   (cell or seen flag) on one read address shared by the cell and seen
//   stores, then the writes. A generator or solver step passes S_TOP, S_TOPW,
//   four S_NB/S_DEC rounds, S_WR2, S_OUTR, S_OUTW and S_OUT before its
//   result is registered, and only then is the next item taken; seeding,
//   goal and finished ticks skip the neighbour reads.
//   While the receiver stalls the result waits in the output register; one
//   more item is taken and worked, then held at its last state until the
//   register frees, and the input is not ready meanwhile.
//   After reset, and after every config write, a clearing pass over every
//   cell entry wipes the cell and seen stores; input items are held off
//   during the pass, config writes are always accepted.
//   Reset values: 40 columns, 25 rows, start at column 0 row 0.
// ----------------------------------------------------------------------------
module maze_generate_and_solve_top #(
  parameter int MAX_WIDTH  = mgs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mgs_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] random_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  phase,
  output logic [1:0]  action,
  output logic [5:0]  cur_col,
  output logic [4:0]  cur_row,
  output logic [1:0]  move_dir,
  output logic [3:0]  cell_walls_open,
  output logic [11:0] visited_count,
  output logic [11:0] solve_step_count,
  output logic [10:0] route_length,
  output logic [11:0] stack_depth,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam int NC = 1 << AW;
  localparam int DW = AW + 1;
  localparam int ROW_STEP = 1 << CW;

  localparam logic [3:0] S_IDLE = 4'd0, S_CLR = 4'd1, S_TOP = 4'd2, S_TOPW = 4'd3,
                         S_NB = 4'd4, S_DEC = 4'd5, S_WR2 = 4'd6, S_OUTR = 4'd7,
                         S_OUTW = 4'd8, S_OUT = 4'd9;

  logic [3:0] state;

  // registers
  logic [6:0] width_in_use;
  logic [5:0] height_in_use;
  logic [5:0] start_col;
  logic [4:0] start_row;

  // effective geometry
  logic [8:0] ew, eh;
  always_comb begin
    ew = (width_in_use < 7'd2) ? 9'd2 : 9'(width_in_use);
    if (ew > 9'(MAX_WIDTH)) ew = 9'(MAX_WIDTH);
    eh = (height_in_use < 6'd2) ? 9'd2 : 9'(height_in_use);
    if (eh > 9'(MAX_HEIGHT)) eh = 9'(MAX_HEIGHT);
  end
  logic [CW-1:0] last_c;
  logic [RW-1:0] last_r;
  logic [CW-1:0] sc;
  logic [RW-1:0] sr;
  assign last_c = CW'(ew - 9'd1);
  assign last_r = RW'(eh - 9'd1);
  assign sc = (9'(start_col) > 9'(last_c)) ? last_c : CW'(start_col);
  assign sr = (9'(start_row) > 9'(last_r)) ? last_r : RW'(start_row);
  logic [AW-1:0] start_idx, goal_idx;
  assign start_idx = {sr, sc};
  assign goal_idx  = {last_r, last_c};
  logic [12:0] total;
  logic [17:0] total_w;
  assign total_w = 18'(ew) * 18'(eh);
  assign total = 13'(total_w);

  // memories: cell store, seen flags, two stacks
  logic [4:0]    cell_mem [NC];
  logic          seen_mem [NC];
  logic [AW-1:0] gstk [NC];
  logic [AW-1:0] sstk [NC];

  // run state
  logic [2:0]  run_phase;
  logic [DW-1:0] gen_depth, solve_depth;
  logic [11:0] cells_visited, solver_steps;
  logic [AW-1:0] clr_idx;
  logic [15:0] word;
  logic [AW-1:0] cur;
  logic [4:0]  cur_cell;
  logic [1:0]  nb_i;
  logic [3:0]  cand;
  logic [1:0]  dir;
  logic [1:0]  act;
  logic [AW-1:0] rd_addr;
  logic [4:0]  cell_q;
  logic        seen_q;
  logic [AW-1:0] gtop_q, stop_q;
  logic        pend;
  logic        out_fire;

  assign in_ready  = state == S_IDLE;
  assign cfg_ready = 1'b1;
  assign out_fire  = (state == S_OUT) && !cfg_valid && (!out_valid || out_ready);

  logic gen_mode;
  assign gen_mode = run_phase == mgs_pkg::PH_GEN;

  // active stack top and depth
  logic [DW-1:0] depth_a;
  logic [AW-1:0] top_a;
  assign depth_a = gen_mode ? gen_depth : solve_depth;
  assign top_a   = gen_mode ? gtop_q : stop_q;

  // neighbour address and bounds for direction d
  function automatic logic [AW-1:0] nbr(input logic [AW-1:0] i, input logic [1:0] d);
    logic [AW-1:0] r;
    case (d)
      mgs_pkg::DIR_N: r = i - AW'(ROW_STEP);
      mgs_pkg::DIR_E: r = i + AW'(1);
      mgs_pkg::DIR_S: r = i + AW'(ROW_STEP);
      default:        r = i - AW'(1);
    endcase
    return r;
  endfunction

  logic inb;
  always_comb begin
    case (nb_i)
      mgs_pkg::DIR_N: inb = cur[AW-1:CW] != '0;
      mgs_pkg::DIR_E: inb = cur[CW-1:0] < last_c;
      mgs_pkg::DIR_S: inb = cur[AW-1:CW] < last_r;
      default:        inb = cur[CW-1:0] != '0;
    endcase
  end

  logic [2:0] ncand;
  assign ncand = 3'($countones(cand));
  logic [1:0] k;
  assign k = mgs_pkg::pick_mod(word, ncand);
  // k-th set bit of cand
  logic [1:0] chosen;
  always_comb begin
    logic [1:0] cnt;
    cnt = 2'd0;
    chosen = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (cand[d]) begin
        if (cnt == k) chosen = 2'(d);
        cnt = cnt + 2'd1;
      end
    end
  end

  // synchronous memory reads
  always_ff @(posedge clk) begin
    cell_q <= cell_mem[rd_addr];
    seen_q <= seen_mem[rd_addr];
    gtop_q <= gstk[AW'(gen_depth - DW'(1))];
    stop_q <= sstk[AW'(solve_depth - DW'(1))];
  end

  always_comb begin
    unique case (state) inside
      S_NB:          rd_addr = nbr(cur, nb_i);
      S_OUTW, S_OUT: rd_addr = top_a;
      default:       rd_addr = cur;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_idx <= '0; pend <= 1'b0;
      width_in_use <= mgs_pkg::RST_WIDTH; height_in_use <= mgs_pkg::RST_HEIGHT;
      start_col <= '0; start_row <= '0;
      run_phase <= mgs_pkg::PH_GEN; gen_depth <= DW'(1); solve_depth <= '0;
      cells_visited <= 12'd1; solver_steps <= '0;
    end else begin
      if (cfg_valid) begin
        // restart the whole run with a clearing pass
        unique case (cfg_index)
          mgs_pkg::REG_WIDTH:     width_in_use <= cfg_data;
          mgs_pkg::REG_HEIGHT:    height_in_use <= cfg_data[5:0];
          mgs_pkg::REG_START_COL: start_col <= cfg_data[5:0];
          mgs_pkg::REG_START_ROW: start_row <= cfg_data[4:0];
          default: ;
        endcase
        state <= S_CLR; clr_idx <= '0;
      end else begin
        unique case (state)
          S_CLR: begin
            cell_mem[clr_idx] <= '0;
            seen_mem[clr_idx] <= 1'b0;
            clr_idx <= clr_idx + AW'(1);
            if (clr_idx == AW'(NC - 1)) begin
              state <= S_WR2; pend <= 1'b1;
              run_phase <= mgs_pkg::PH_GEN; gen_depth <= DW'(1); solve_depth <= '0;
              cells_visited <= 12'd1; solver_steps <= '0;
            end
          end
          S_IDLE: begin
            if (in_valid && in_ready) begin
              word <= random_word; act <= mgs_pkg::ACT_NONE; dir <= mgs_pkg::DIR_N;
              cand <= '0; nb_i <= mgs_pkg::DIR_N;
              state <= S_TOP;
            end
          end
          S_TOP: state <= S_TOPW;
          S_TOPW: begin
            if (gen_mode) begin
              if (13'(cells_visited) < total && gen_depth != '0) begin
                cur <= gtop_q; state <= S_NB;
              end else begin
                sstk[0] <= '0; seen_mem[0] <= 1'b1; solve_depth <= DW'(1);
                solver_steps <= 12'd1; run_phase <= mgs_pkg::PH_SEEDED;
                state <= S_OUTR;
              end
            end else if (run_phase == mgs_pkg::PH_SEEDED ||
                         run_phase == mgs_pkg::PH_SOLVING) begin
              if (solve_depth == '0) begin
                run_phase <= mgs_pkg::PH_STUCK; state <= S_OUTR;
              end else begin
                cur <= stop_q;
                seen_mem[stop_q] <= 1'b1;
                if (stop_q == goal_idx) begin
                  run_phase <= mgs_pkg::PH_SOLVED; act <= mgs_pkg::ACT_GOAL;
                  state <= S_OUTR;
                end else begin
                  run_phase <= mgs_pkg::PH_SOLVING; state <= S_NB;
                end
              end
            end else state <= S_OUTR;
          end
          S_NB: begin
            // issue neighbour read; evaluated in S_DEC next cycle
            state <= S_DEC;
            cur_cell <= cell_mem[cur];
          end
          S_DEC: begin
            if (gen_mode) cand[nb_i] <= inb && !cell_q[4];
            else cand[nb_i] <= inb && cur_cell[nb_i] && !seen_q;
            if (nb_i == mgs_pkg::DIR_W) state <= S_WR2;
            else begin nb_i <= nb_i + 2'd1; state <= S_NB; end
          end
          S_WR2: begin
            if (pend) begin
              // end of clearing: mark start cell
              pend <= 1'b0;
              cell_mem[start_idx] <= mgs_pkg::VISITED_FLAG;
              gstk[0] <= start_idx;
              state <= S_IDLE;
            end else if (ncand != 3'd0) begin
              dir <= chosen; act <= mgs_pkg::ACT_ADV;
              state <= S_OUTR;
              if (gen_mode) begin
                // unvisited neighbour holds no open walls yet
                cell_mem[nbr(cur, chosen)] <= mgs_pkg::VISITED_FLAG |
                                              {1'b0, mgs_pkg::back_bit(chosen)};
                cell_mem[cur] <= cur_cell | {1'b0, mgs_pkg::open_bit(chosen)};
                gstk[AW'(gen_depth)] <= nbr(cur, chosen);
                gen_depth <= gen_depth + DW'(1);
                cells_visited <= cells_visited + 12'd1;
              end else begin
                sstk[AW'(solve_depth)] <= nbr(cur, chosen);
                solve_depth <= solve_depth + DW'(1);
                solver_steps <= solver_steps + 12'd1;
              end
            end else begin
              act <= mgs_pkg::ACT_BACK;
              if (gen_mode) gen_depth <= gen_depth - DW'(1);
              else begin
                solve_depth <= solve_depth - DW'(1);
                if (solve_depth == DW'(1)) run_phase <= mgs_pkg::PH_STUCK;
              end
              state <= S_OUTR;
            end
          end
          S_OUTR: state <= S_OUTW;
          S_OUTW: state <= S_OUT;
          S_OUT: begin
            if (out_fire) state <= S_IDLE;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result fields, loaded once the read of the top cell completes
  always_ff @(posedge clk) begin
    if (out_fire) begin
      phase <= run_phase;
      action <= act;
      move_dir <= dir;
      cur_col <= (depth_a != '0) ? 6'(top_a[CW-1:0]) : 6'd0;
      cur_row <= (depth_a != '0) ? 5'(top_a[AW-1:CW]) : 5'd0;
      cell_walls_open <= (depth_a != '0) ? cell_q[3:0] : 4'd0;
      visited_count <= cells_visited;
      solve_step_count <= solver_steps;
      route_length <= (solve_depth != '0) ? 11'(solve_depth - DW'(1)) : 11'd0;
      stack_depth <= 12'(depth_a);
    end
  end

endmodule
